// ===== rtl/cfar_signal_activity_detector_defines.svh =====
// assertion macros for the activity detector
`ifndef CFAR_SIGNAL_ACTIVITY_DETECTOR_DEFINES_SVH
`define CFAR_SIGNAL_ACTIVITY_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CSAD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csad check failed");

// antecedent implies consequent in the cycle after
`define CSAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csad check failed");

`else

`define CSAD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CSAD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/csad_pkg.sv =====
// types and constants of the activity detector
package csad_pkg;

   // channel widths
   localparam int REQ_W      = 48;
   localparam int RSP_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int IN_E_W     = 32;
   localparam int CENT_W     = 16;

   // register widths
   localparam int TF_W   = 8;
   localparam int LF_W   = 8;
   localparam int ENDF_W = 10;
   localparam int EFAC_W = 8;
   localparam int LOW_W  = 10;

   localparam logic [LOW_W-1:0] LOW_MAX = 10'd1023;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_FACTOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_FRAMES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FRAMES       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FACTOR       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CENTROID     = 3'd4;

   // register reset values
   localparam logic [TF_W-1:0]   TF_RESET   = 8'd160;
   localparam logic [LF_W-1:0]   LF_RESET   = 8'd25;
   localparam logic [ENDF_W-1:0] ENDF_RESET = 10'd100;
   localparam logic [EFAC_W-1:0] EFAC_RESET = 8'd77;
   localparam logic [CENT_W-1:0] MC_RESET   = 16'd1;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_LEARN = 2'd1,
      PHASE_TRACK = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_CMP,
      ST_EMUL,
      ST_ECMP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/cfar_signal_activity_detector.sv =====
// cell-averaging start detector with energy and centroid end tracking
//
// One request word carries a frame's energy and spectral centroid; one
// response word follows per frame. Only one frame is in work at a time and
// req_tready is high while the engine waits for a frame; a finished word may
// sit in the response register while the next frame is taken. Idle frames
// before the history ring is full go straight to the done state. Once full,
// an idle frame sums WINDOW-GUARD ring entries through the single read port
// of the ring memory, one entry a cycle. A tracked frame that moves the
// reference goes through a radix-4 divide by ten of (EW+5)/2 steps, EW being
// ENERGY_WIDTH capped at 32. A response word held back by rsp_tready stalls
// the next finished frame in the done state. The ring memory needs no
// clearing after reset: an entry is read only after it has been written.
`include "cfar_signal_activity_detector_defines.svh"

module cfar_signal_activity_detector #(
   parameter int WINDOW       = 20,
   parameter int GUARD        = 2,
   parameter int ENERGY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // frame_energy [31:0], centroid_hz [47:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [csad_pkg::REQ_W-1:0]          req_tdata,
   // phase [1:0], start_seen [2], end_seen [3], history_full [4], zero [7:5]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [csad_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                                csr_we,
   input  logic [csad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csad_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int EW        = (ENERGY_WIDTH < csad_pkg::IN_E_W) ? ENERGY_WIDTH
                                                                  : csad_pkg::IN_E_W;
   localparam int PTR_W     = $clog2(WINDOW);
   localparam int PTR_X     = PTR_W + 1;
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam bit GUARD_ALL = (GUARD >= WINDOW);
   localparam int CNT       = GUARD_ALL ? 0 : WINDOW - GUARD;
   localparam int GMOD      = GUARD % WINDOW;
   localparam int SUM_W     = EW + FILL_W;
   localparam int MUL_W     = SUM_W + csad_pkg::TF_W;
   localparam int DIV_STEPS = (EW + 5) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   // state machine
   csad_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [csad_pkg::TF_W-1:0]   tf_ff, tf_in;
   logic [csad_pkg::LF_W-1:0]   lf_ff, lf_in;
   logic [csad_pkg::ENDF_W-1:0] endf_ff, endf_in;
   logic [csad_pkg::EFAC_W-1:0] efac_ff, efac_in;
   logic [csad_pkg::CENT_W-1:0] mc_ff, mc_in;

   // detector state
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic                       active_ff, active_in;
   logic [csad_pkg::LF_W-1:0]  learn_ff, learn_in;
   logic                       refv_ff, refv_in;
   logic [EW-1:0]              ref_ff, ref_in;
   logic [csad_pkg::LOW_W-1:0] low_ff, low_in;

   // work registers
   logic [EW-1:0]               e_ff, e_in;
   logic [csad_pkg::CENT_W-1:0] c_ff, c_in;
   logic [SUM_W-1:0]            acc_ff, acc_in;
   logic [PTR_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0]           rd_cnt_ff, rd_cnt_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [MUL_W-1:0]            prod_ff, prod_in;
   logic [MUL_W-1:0]            lhs_ff, lhs_in;
   logic [DIV_W-1:0]            div_x_ff, div_x_in;
   logic [3:0]                  div_rem_ff, div_rem_in;
   logic [DCNT_W-1:0]           div_cnt_ff, div_cnt_in;
   logic                        pend_start_ff, pend_start_in;
   logic                        pend_end_ff, pend_end_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [csad_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // ring memory
   logic [EW-1:0] ring_mem_ff [WINDOW];
   logic [EW-1:0] ring_q_ff;
   logic          ring_we;
   logic          ring_re;

   // combinational helpers
   logic                       req_fire;
   logic [EW-1:0]              e_new;
   logic [FILL_W-1:0]          fill_new;
   logic [csad_pkg::LF_W-1:0]  learn_new;
   logic [csad_pkg::LOW_W-1:0] low_new;
   logic [PTR_W-1:0]           rd_start;
   logic [SUM_W-1:0]           mul_a;
   logic [csad_pkg::TF_W-1:0]  mul_b;
   logic [MUL_W-1:0]           mul_p;
   logic [5:0]                 div_r;
   logic [1:0]                 div_q;
   logic [3:0]                 div_rem_next;
   logic                       is_low;
   logic                       ended;
   csad_pkg::phase_type        phase_now;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == csad_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign e_new      = req_tdata[EW-1:0];

   // shared multiplier
   assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

   // first guarded read address: GUARD entries back from the newest
   always_comb begin
      if (ptr_ff >= PTR_W'(GMOD)) begin
         rd_start = ptr_ff - PTR_W'(GMOD);
      end else begin
         rd_start = PTR_W'(PTR_X'(ptr_ff) + PTR_X'(WINDOW - GMOD));
      end
   end

   // radix-4 divide by ten digit
   always_comb begin
      div_r = {div_rem_ff, div_x_ff[DIV_W-1 -: 2]};
      if (div_r >= 6'd30) begin
         div_q        = 2'd3;
         div_rem_next = 4'(div_r - 6'd30);
      end else if (div_r >= 6'd20) begin
         div_q        = 2'd2;
         div_rem_next = 4'(div_r - 6'd20);
      end else if (div_r >= 6'd10) begin
         div_q        = 2'd1;
         div_rem_next = 4'(div_r - 6'd10);
      end else begin
         div_q        = 2'd0;
         div_rem_next = div_r[3:0];
      end
   end

   // configuration decode
   always_comb begin
      tf_in   = tf_ff;
      lf_in   = lf_ff;
      endf_in = endf_ff;
      efac_in = efac_ff;
      mc_in   = mc_ff;
      if (csr_we) begin
         unique case (csr_index)
            csad_pkg::CSR_THRESHOLD_FACTOR: tf_in   = csr_wdata[csad_pkg::TF_W-1:0];
            csad_pkg::CSR_LEARN_FRAMES:     lf_in   = csr_wdata[csad_pkg::LF_W-1:0];
            csad_pkg::CSR_END_FRAMES:       endf_in = csr_wdata[csad_pkg::ENDF_W-1:0];
            csad_pkg::CSR_END_FACTOR:       efac_in = csr_wdata[csad_pkg::EFAC_W-1:0];
            csad_pkg::CSR_MIN_CENTROID:     mc_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      learn_in      = learn_ff;
      refv_in       = refv_ff;
      ref_in        = ref_ff;
      low_in        = low_ff;
      e_in          = e_ff;
      c_in          = c_ff;
      acc_in        = acc_ff;
      rd_idx_in     = rd_idx_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_vld_in     = 1'b0;
      prod_in       = prod_ff;
      lhs_in        = lhs_ff;
      div_x_in      = div_x_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ring_we       = 1'b0;
      ring_re       = 1'b0;
      mul_a         = acc_ff;
      mul_b         = tf_ff;
      fill_new      = (fill_ff < FILL_W'(WINDOW)) ? fill_ff + 1'b1 : fill_ff;
      learn_new     = (learn_ff < lf_ff) ? learn_ff + 1'b1 : learn_ff;
      low_new       = (low_ff < csad_pkg::LOW_MAX) ? low_ff + 1'b1 : low_ff;
      is_low        = (MUL_W'({e_ff, 8'h00}) < prod_ff) || (c_ff < mc_ff);
      ended         = (low_new >= endf_ff);
      if (!active_ff) begin
         phase_now = csad_pkg::PHASE_IDLE;
      end else if (learn_ff < lf_ff) begin
         phase_now = csad_pkg::PHASE_LEARN;
      end else begin
         phase_now = csad_pkg::PHASE_TRACK;
      end

      unique case (state_ff)
         csad_pkg::ST_IDLE: begin
            if (req_fire) begin
               e_in          = e_new;
               c_in          = req_tdata[csad_pkg::IN_E_W +: csad_pkg::CENT_W];
               pend_start_in = 1'b0;
               pend_end_in   = 1'b0;
               state_in      = csad_pkg::ST_DONE;
               if (!active_ff) begin
                  // push the energy into the ring
                  ring_we   = 1'b1;
                  ptr_in    = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
                  fill_in   = fill_new;
                  acc_in    = '0;
                  rd_idx_in = rd_start;
                  rd_cnt_in = '0;
                  if (fill_new == FILL_W'(WINDOW)) begin
                     if (GUARD_ALL) begin
                        pend_start_in = (e_new != '0);
                        active_in     = (e_new != '0);
                     end else begin
                        state_in = csad_pkg::ST_SUM;
                     end
                  end
               end else begin
                  learn_in = learn_new;
                  if (learn_new >= lf_ff) begin
                     if (!refv_ff) begin
                        ref_in  = e_new;
                        refv_in = 1'b1;
                        low_in  = '0;
                     end else begin
                        state_in = csad_pkg::ST_EMUL;
                     end
                  end
               end
            end
         end
         csad_pkg::ST_SUM: begin
            // one read issued and one entry accumulated per cycle
            if (rd_cnt_ff != FILL_W'(CNT)) begin
               ring_re   = 1'b1;
               rd_vld_in = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
               rd_idx_in = (rd_idx_ff == '0) ? PTR_W'(WINDOW - 1) : rd_idx_ff - 1'b1;
            end
            if (rd_vld_ff) begin
               acc_in = acc_ff + SUM_W'(ring_q_ff);
            end
            if (rd_cnt_ff == FILL_W'(CNT) && !rd_vld_ff) begin
               state_in = csad_pkg::ST_MUL;
            end
         end
         csad_pkg::ST_MUL: begin
            prod_in  = mul_p;
            lhs_in   = (MUL_W'(e_ff) * MUL_W'(CNT)) << 4;
            state_in = csad_pkg::ST_CMP;
         end
         csad_pkg::ST_CMP: begin
            if (lhs_ff > prod_ff) begin
               pend_start_in = 1'b1;
               active_in     = 1'b1;
            end
            state_in = csad_pkg::ST_DONE;
         end
         csad_pkg::ST_EMUL: begin
            mul_a    = SUM_W'(ref_ff);
            mul_b    = efac_ff;
            prod_in  = mul_p;
            state_in = csad_pkg::ST_ECMP;
         end
         csad_pkg::ST_ECMP: begin
            if (is_low) begin
               state_in = csad_pkg::ST_DONE;
               if (ended) begin
                  pend_end_in = 1'b1;
                  active_in   = 1'b0;
                  refv_in     = 1'b0;
                  low_in      = '0;
                  learn_in    = '0;
               end else begin
                  low_in = low_new;
               end
            end else begin
               // reference moves to (9 * ref + energy) / 10
               low_in     = '0;
               div_x_in   = DIV_W'({ref_ff, 3'b000}) + DIV_W'(ref_ff) + DIV_W'(e_ff);
               div_rem_in = '0;
               div_cnt_in = DCNT_W'(DIV_STEPS);
               state_in   = csad_pkg::ST_DIV;
            end
         end
         csad_pkg::ST_DIV: begin
            if (div_cnt_ff != '0) begin
               div_x_in   = {div_x_ff[DIV_W-3:0], div_q};
               div_rem_in = div_rem_next;
               div_cnt_in = div_cnt_ff - 1'b1;
            end else begin
               ref_in   = div_x_ff[EW-1:0];
               state_in = csad_pkg::ST_DONE;
            end
         end
         csad_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, (fill_ff == FILL_W'(WINDOW)), pend_end_ff,
                               pend_start_ff, phase_now};
               state_in     = csad_pkg::ST_IDLE;
            end
         end
         default: state_in = csad_pkg::ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tf_ff        <= csad_pkg::TF_RESET;
         lf_ff        <= csad_pkg::LF_RESET;
         endf_ff      <= csad_pkg::ENDF_RESET;
         efac_ff      <= csad_pkg::EFAC_RESET;
         mc_ff        <= csad_pkg::MC_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         active_ff    <= 1'b0;
         learn_ff     <= '0;
         refv_ff      <= 1'b0;
         ref_ff       <= '0;
         low_ff       <= '0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tf_ff        <= tf_in;
         lf_ff        <= lf_in;
         endf_ff      <= endf_in;
         efac_ff      <= efac_in;
         mc_ff        <= mc_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         active_ff    <= active_in;
         learn_ff     <= learn_in;
         refv_ff      <= refv_in;
         ref_ff       <= ref_in;
         low_ff       <= low_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      e_ff          <= e_in;
      c_ff          <= c_in;
      acc_ff        <= acc_in;
      rd_idx_ff     <= rd_idx_in;
      prod_ff       <= prod_in;
      lhs_ff        <= lhs_in;
      div_x_ff      <= div_x_in;
      div_rem_ff    <= div_rem_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem_ff[ptr_ff] <= e_new;
      end
      if (ring_re) begin
         ring_q_ff <= ring_mem_ff[rd_idx_ff];
      end
   end

   // checks
   `CSAD_ASSERT_IMPLY(a_ptr_range, clock, reset, 1'b1, PTR_X'(ptr_ff) < PTR_X'(WINDOW))
   `CSAD_ASSERT_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= FILL_W'(WINDOW))
   `CSAD_ASSERT_IMPLY(a_idle_clean, clock, reset, !active_ff,
                      learn_ff == '0 && !refv_ff && low_ff == '0)
   `CSAD_ASSERT_NEXT(a_busy_after_take, clock, reset, req_fire,
                     state_ff != csad_pkg::ST_IDLE)
   `CSAD_ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                      $past(state_ff == csad_pkg::ST_DONE))

endmodule
